// ===== src/lidar_frame_parser_crc8_unit_macros.svh =====
// assertion macros shared by the lidar frame parser rtl
// used by lidar_frame_parser_crc8_unit; expects clk_i and rst_ni in scope
`ifndef LIDAR_FRAME_PARSER_CRC8_UNIT_MACROS_SVH
`define LIDAR_FRAME_PARSER_CRC8_UNIT_MACROS_SVH

// same-cycle implication
`define LFPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfpc assertion failed");

// next-cycle implication
`define LFPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfpc assertion failed");

`endif

// ===== src/lfpc_pkg.sv =====
// package for the lidar frame parser: sizes, constants, crc step function
// no dependencies
package lfpc_pkg;

  localparam int MAX_POINTS = 12;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SPAN_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_IDX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_IDX   = 1'd1;

  localparam logic [7:0]        HEADER_RST = 8'h54;
  localparam logic [SPAN_W-1:0] SPAN_RST   = 16'd1000;

  localparam logic [7:0] CRC_POLY   = 8'h4D;
  localparam logic [4:0] COUNT_MASK = 5'h1F;

  // angle arithmetic in centidegrees, wrapped at one turn
  localparam logic [16:0] ANGLE_MOD  = 17'd36000;
  localparam logic [16:0] ROUND_HALF = 17'd50;
  // x / 100 for x below one turn: (x * 5243) >> 19
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          RECIP_SH   = 19;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [7:0] crc_feed(logic [7:0] c, logic [7:0] b);
    logic [7:0] x;
    x = c ^ b;
    for (int k = 0; k < 8; k++) begin
      x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

endpackage

// ===== src/lfpc_if.sv =====
// channel interfaces of the lidar frame parser: byte in, point out, config write
// depends on lfpc_pkg
interface lfpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfpc_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  angle_bin;
  logic [15:0] distance_mm;
  logic [7:0]  confidence;
  logic [3:0]  point_number;
  logic [15:0] frame_number;
  logic        last_point;
  modport source (output valid, output angle_bin, output distance_mm, output confidence,
                  output point_number, output frame_number, output last_point,
                  input ready);
  modport sink   (input valid, input angle_bin, input distance_mm, input confidence,
                  input point_number, input frame_number, input last_point,
                  output ready);
endinterface

interface lfpc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lfpc_pkg::CFG_IDX_W-1:0]     addr;
  logic [lfpc_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== src/lfpc_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on lfpc_pkg
module lfpc_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lfpc_pkg::SPAN_W-1:0]      dividend_i,
  input  logic [lfpc_pkg::CNT_W-1:0]       divisor_i,
  output lfpc_pkg::div_stat_t              stat_o,
  output logic [lfpc_pkg::SPAN_W-1:0]      quot_o,
  output logic [lfpc_pkg::CNT_W-1:0]       rem_o
);

  localparam int STEP_W = $clog2(lfpc_pkg::SPAN_W + 1);

  logic [lfpc_pkg::SPAN_W-1:0] dvd_q, dvd_d;
  logic [lfpc_pkg::CNT_W-1:0]  dvs_q;
  logic [lfpc_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [lfpc_pkg::CNT_W:0]    trial;
  logic [STEP_W-1:0]           step_q;
  logic                        busy_q, done_q;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, dvd_q[lfpc_pkg::SPAN_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = lfpc_pkg::CNT_W'(trial - {1'b0, dvs_q});
      dvd_d = {dvd_q[lfpc_pkg::SPAN_W-2:0], 1'b1};
    end else begin
      rem_d = lfpc_pkg::CNT_W'(trial);
      dvd_d = {dvd_q[lfpc_pkg::SPAN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(lfpc_pkg::SPAN_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;
  assign rem_o       = rem_q;

endmodule

// ===== src/lidar_frame_parser_crc8_unit.sv =====
// top level of the lidar frame parser: byte parser, crc-8 check, point store, point emitter
// depends on lfpc_pkg, lfpc_if, lfpc_div and the assertion macro header
// input: bytes are accepted whenever no frame is being emitted
// after a frame whose crc matches, input is held off while the span/count divider
//   runs (one quotient bit a cycle) and then while the points are emitted in turn,
//   each by reading the store and the angle bin, then loading the output register once it is free
// reset: parser back to header search, frame counter 0, header 0x54, span 1000;
//   the point store is not cleared
`include "lidar_frame_parser_crc8_unit_macros.svh"

module lidar_frame_parser_crc8_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfpc_cfg_if.sink    cfg_i,
  lfpc_in_if.sink     in_i,
  lfpc_out_if.source  out_o
);

  // parser phases
  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_FIXED  = 2'd1;
  localparam logic [1:0] PH_POINTS = 2'd2;
  localparam logic [1:0] PH_TAIL   = 2'd3;

  // emitter states
  localparam logic [1:0] EM_IDLE = 2'd0;
  localparam logic [1:0] EM_DIV  = 2'd1;
  localparam logic [1:0] EM_RD   = 2'd2;
  localparam logic [1:0] EM_OUT  = 2'd3;

  // byte offsets inside the fixed header and the tail
  localparam logic [2:0] POS_LEN     = 3'd1;
  localparam logic [2:0] POS_ANG_LO  = 3'd4;
  localparam logic [2:0] POS_ANG_HI  = 3'd5;
  localparam logic [2:0] POS_CRC     = 3'd4;

  localparam logic [1:0] SUB_LO   = 2'd0;
  localparam logic [1:0] SUB_HI   = 2'd1;
  localparam logic [1:0] SUB_CONF = 2'd2;

  localparam int PT_W  = lfpc_pkg::PT_W;
  localparam int CNT_W = lfpc_pkg::CNT_W;

  // configuration registers
  logic [7:0]                  header_q;
  logic [lfpc_pkg::SPAN_W-1:0] span_q;

  // parser state
  logic [1:0]        phase_q;
  logic [2:0]        pos_q;
  logic [1:0]        sub_q;
  logic [PT_W-1:0]   pt_wr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [7:0]        crc_q;
  logic [15:0]       start_q;
  logic [7:0]        dist_lo_q, dist_hi_q;
  logic [15:0]       frames_q;

  // point store, one entry per point: {confidence, distance}
  logic [23:0]       pt_mem [lfpc_pkg::MAX_POINTS];
  logic [23:0]       rd_data_q;
  logic              mem_we;

  // emitter state
  logic [1:0]        em_q;
  logic [CNT_W-1:0]  n_q;
  logic [15:0]       em_start_q;
  logic [15:0]       em_frame_q;
  logic [15:0]       qs_q;
  logic [CNT_W-1:0]  rs_q, r_q;
  logic [15:0]       acc_q;
  logic [PT_W-1:0]   pt_rd_q;
  logic [8:0]        bin_q;

  // output register
  logic              out_valid_q;
  logic [8:0]        o_bin_q;
  logic [15:0]       o_dist_q;
  logic [7:0]        o_conf_q;
  logic [3:0]        o_num_q;
  logic [15:0]       o_frame_q;
  logic              o_last_q;

  logic              in_fire, cfg_fire, frame_ok, out_load, em_last;
  logic [4:0]        len_raw;
  logic [CNT_W-1:0]  len_cnt;

  lfpc_pkg::div_stat_t         div_stat;
  logic [lfpc_pkg::SPAN_W-1:0] div_quot;
  logic [CNT_W-1:0]            div_rem;

  // angle stepping
  logic [16:0]       acc0_sum, qs_sum, acc_sum;
  logic [15:0]       acc0, qs_mod, acc_next;
  logic [CNT_W:0]    r_sum;
  logic [CNT_W-1:0]  r_next;
  logic              r_carry;
  logic [28:0]       bin_prod;

  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign cfg_i.ready = 1'b1;
  // bytes are held off while a good frame is turned into points
  assign in_i.ready  = (em_q == EM_IDLE);

  // point count: zero or above the maximum means the maximum
  assign len_raw = in_i.rx_byte[4:0] & lfpc_pkg::COUNT_MASK;
  assign len_cnt = (len_raw == 5'd0 || 32'(len_raw) > lfpc_pkg::MAX_POINTS)
                 ? CNT_W'(lfpc_pkg::MAX_POINTS) : CNT_W'(len_raw);

  // last byte of the tail is the crc; compare against everything before it
  assign frame_ok = in_fire && (phase_q == PH_TAIL) && (pos_q == POS_CRC) &&
                    (crc_q == in_i.rx_byte);

  assign mem_we = in_fire && (phase_q == PH_POINTS) && (sub_q == SUB_CONF);

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= lfpc_pkg::HEADER_RST;
      span_q   <= lfpc_pkg::SPAN_RST;
    end else if (cfg_fire) begin
      case (cfg_i.addr)
        lfpc_pkg::CFG_HEADER_IDX: header_q <= cfg_i.data[7:0];
        lfpc_pkg::CFG_SPAN_IDX:   span_q   <= cfg_i.data[lfpc_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // byte parser
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      pos_q    <= '0;
      sub_q    <= SUB_LO;
      pt_wr_q  <= '0;
      cnt_q    <= CNT_W'(lfpc_pkg::MAX_POINTS);
      crc_q    <= '0;
      start_q  <= '0;
      frames_q <= '0;
    end else if (in_fire) begin
      case (phase_q)
        PH_SEARCH: begin
          if (in_i.rx_byte == header_q) begin
            crc_q   <= lfpc_pkg::crc_feed(8'd0, in_i.rx_byte);
            pos_q   <= POS_LEN;
            phase_q <= PH_FIXED;
          end
        end
        PH_FIXED: begin
          crc_q <= lfpc_pkg::crc_feed(crc_q, in_i.rx_byte);
          case (pos_q)
            POS_LEN:    cnt_q         <= len_cnt;
            POS_ANG_LO: start_q[7:0]  <= in_i.rx_byte;
            POS_ANG_HI: start_q[15:8] <= in_i.rx_byte;
            default: ;
          endcase
          pos_q <= pos_q + 3'd1;
          if (pos_q == POS_ANG_HI) begin
            phase_q <= PH_POINTS;
            sub_q   <= SUB_LO;
            pt_wr_q <= '0;
          end
        end
        PH_POINTS: begin
          crc_q <= lfpc_pkg::crc_feed(crc_q, in_i.rx_byte);
          if (sub_q == SUB_CONF) begin
            sub_q   <= SUB_LO;
            pt_wr_q <= pt_wr_q + PT_W'(1);
            if (CNT_W'(pt_wr_q) + CNT_W'(1) == cnt_q) begin
              phase_q <= PH_TAIL;
              pos_q   <= '0;
            end
          end else begin
            sub_q <= sub_q + 2'd1;
          end
        end
        default: begin
          // tail: end angle and timestamp only go into the crc, crc byte closes
          if (pos_q != POS_CRC) begin
            crc_q <= lfpc_pkg::crc_feed(crc_q, in_i.rx_byte);
            pos_q <= pos_q + 3'd1;
          end else begin
            phase_q <= PH_SEARCH;
            pos_q   <= '0;
            if (frame_ok) begin
              frames_q <= frames_q + 16'd1;
            end
          end
        end
      endcase
    end
  end

  // distance bytes wait here until the confidence byte completes the entry
  always_ff @(posedge clk_i) begin
    if (in_fire && phase_q == PH_POINTS) begin
      if (sub_q == SUB_LO) dist_lo_q <= in_i.rx_byte;
      if (sub_q == SUB_HI) dist_hi_q <= in_i.rx_byte;
    end
  end

  // point store: written by the parser, read by the emitter, never both at once
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pt_mem[pt_wr_q] <= {in_i.rx_byte, dist_hi_q, dist_lo_q};
    end
    if (em_q == EM_RD) begin
      rd_data_q <= pt_mem[pt_rd_q];
    end
  end

  // ---------------------------------------------------------------------
  // span / count divider, once per good frame
  // ---------------------------------------------------------------------
  lfpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_ok),
    .dividend_i (span_q),
    .divisor_i  (cnt_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------------
  // angle of point i in centidegrees, kept modulo one turn:
  //   acc_i = (start + 50 + floor(i * span / n)) mod 36000
  // stepped as acc += span div n, with the remainder carried in r
  // ---------------------------------------------------------------------
  always_comb begin
    acc0_sum = {1'b0, em_start_q} + lfpc_pkg::ROUND_HALF;
    acc0     = (acc0_sum >= lfpc_pkg::ANGLE_MOD)
             ? 16'(acc0_sum - lfpc_pkg::ANGLE_MOD) : 16'(acc0_sum);
    qs_sum   = {1'b0, div_quot};
    qs_mod   = (qs_sum >= lfpc_pkg::ANGLE_MOD)
             ? 16'(qs_sum - lfpc_pkg::ANGLE_MOD) : 16'(qs_sum);

    r_sum   = {1'b0, r_q} + {1'b0, rs_q};
    r_carry = (r_sum >= {1'b0, n_q});
    r_next  = r_carry ? CNT_W'(r_sum - {1'b0, n_q}) : CNT_W'(r_sum);
    acc_sum = {1'b0, acc_q} + {1'b0, qs_q} + {16'd0, r_carry};
    acc_next = (acc_sum >= lfpc_pkg::ANGLE_MOD)
             ? 16'(acc_sum - lfpc_pkg::ANGLE_MOD) : 16'(acc_sum);

    // whole degrees by reciprocal multiply, exact below one turn
    bin_prod = 29'(acc_q * lfpc_pkg::RECIP_100);
  end

  assign em_last  = (CNT_W'(pt_rd_q) + CNT_W'(1) == n_q);
  assign out_load = (em_q == EM_OUT) && (!out_valid_q || out_o.ready);

  // ---------------------------------------------------------------------
  // point emitter
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_q        <= EM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (em_q)
        EM_IDLE: if (frame_ok)          em_q <= EM_DIV;
        EM_DIV:  if (div_stat.done)     em_q <= EM_RD;
        EM_RD:                          em_q <= EM_OUT;
        EM_OUT:  if (out_load)          em_q <= em_last ? EM_IDLE : EM_RD;
        default:                        em_q <= EM_IDLE;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      n_q        <= cnt_q;
      em_start_q <= start_q;
      em_frame_q <= frames_q;
    end
    if (em_q == EM_DIV && div_stat.done) begin
      qs_q    <= qs_mod;
      rs_q    <= div_rem;
      acc_q   <= acc0;
      r_q     <= '0;
      pt_rd_q <= '0;
    end
    if (em_q == EM_RD) begin
      bin_q <= bin_prod[lfpc_pkg::RECIP_SH +: 9];
    end
    if (out_load) begin
      o_bin_q   <= bin_q;
      o_dist_q  <= rd_data_q[15:0];
      o_conf_q  <= rd_data_q[23:16];
      o_num_q   <= 4'(pt_rd_q);
      o_frame_q <= em_frame_q;
      o_last_q  <= em_last;
      acc_q     <= acc_next;
      r_q       <= r_next;
      pt_rd_q   <= pt_rd_q + PT_W'(1);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.angle_bin    = o_bin_q;
  assign out_o.distance_mm  = o_dist_q;
  assign out_o.confidence   = o_conf_q;
  assign out_o.point_number = o_num_q;
  assign out_o.frame_number = o_frame_q;
  assign out_o.last_point   = o_last_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // the divider only runs for the frame being emitted
  `LFPC_ASSERT_IMP(a_div_owned, div_stat.busy, em_q == EM_DIV)
  // the parser never writes the store while points are read out
  `LFPC_ASSERT_IMP(a_no_wr_in_emit, mem_we, em_q == EM_IDLE)
  // the angle accumulator and remainder stay reduced while stepping
  `LFPC_ASSERT_IMP(a_acc_range, em_q == EM_RD || em_q == EM_OUT,
                   acc_q < 16'(lfpc_pkg::ANGLE_MOD) && r_q < n_q)
  // a good crc starts the divider on the next cycle
  `LFPC_ASSERT_NXT(a_div_start, frame_ok, div_stat.busy && em_q == EM_DIV)

endmodule

// ===== tb/sv/lfpc_point_checker.sv =====
// scoreboard for the lidar frame parser: follows the accepted byte stream,
// predicts every point beat and compares it; depends on lfpc_pkg and lfpc_if
`timescale 1ns / 100ps

module lfpc_point_checker
  import lfpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lfpc_cfg_if         cfg_mon,
  lfpc_in_if          byte_mon,
  lfpc_out_if         point_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pend_cnt_o
);

  localparam int unsigned LEAD_BYTES  = 6;
  localparam int unsigned TAIL_BYTES  = 5;
  localparam int unsigned STORE_DEPTH = 3 * MAX_POINTS;
  localparam int unsigned REPORT_MAX  = 10;

  typedef enum logic [1:0] {HUNT, LEAD, POINTS, TAIL} phase_e;

  typedef struct packed {
    logic [8:0]  angle;
    logic [15:0] dist_mm;
    logic [7:0]  conf;
    logic [3:0]  pnum;
    logic [15:0] fnum;
    logic        last;
  } point_t;

  // predictor state
  phase_e      phase;
  int unsigned pos;
  int unsigned npts;
  logic [7:0]  crc_acc;
  logic [15:0] start_ang;
  logic [7:0]  store [STORE_DEPTH];
  logic [15:0] frames_ok;
  logic [7:0]  hdr_val;
  logic [15:0] span_val;

  point_t      pending_points [$];
  int unsigned miss_cnt;

  // bit-serial crc-8, msb first
  function automatic logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    int         k;
    r = c;
    for (k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // rounded whole-degree bin of point idx out of n
  function automatic logic [8:0] bin_of(logic [15:0] sa, int unsigned idx, int unsigned n,
                                        logic [15:0] span);
    longint unsigned num;
    num = sa * n + idx * span + 50 * n;
    return 9'((num / (100 * n)) % 360);
  endfunction

  task automatic follow_byte(input logic [7:0] b);
    int unsigned pts_end;
    int unsigned i;
    point_t      p;
    pts_end = LEAD_BYTES + 3 * npts;
    case (phase)
      HUNT: begin
        if (b == hdr_val) begin
          crc_acc = crc_byte(8'h00, b);
          pos     = 1;
          phase   = LEAD;
        end
      end
      LEAD: begin
        crc_acc = crc_byte(crc_acc, b);
        if (pos == 1) begin
          npts = b & COUNT_MASK;
          if (npts == 0 || npts > MAX_POINTS) npts = MAX_POINTS;
        end else if (pos == 4) begin
          start_ang[7:0] = b;
        end else if (pos == 5) begin
          start_ang[15:8] = b;
        end
        pos++;
        if (pos >= LEAD_BYTES) phase = POINTS;
      end
      POINTS: begin
        crc_acc = crc_byte(crc_acc, b);
        if (pos >= LEAD_BYTES && pos - LEAD_BYTES < STORE_DEPTH) store[pos - LEAD_BYTES] = b;
        pos++;
        if (pos >= pts_end) phase = TAIL;
      end
      default: begin
        if (pos + 1 < pts_end + TAIL_BYTES) begin
          crc_acc = crc_byte(crc_acc, b);
          pos++;
        end else begin
          phase = HUNT;
          pos   = 0;
          if (crc_acc == b) begin
            for (i = 0; i < npts; i++) begin
              p.angle   = bin_of(start_ang, i, npts, span_val);
              p.dist_mm = {store[3 * i + 1], store[3 * i]};
              p.conf    = store[3 * i + 2];
              p.pnum    = 4'(i);
              p.fnum    = frames_ok;
              p.last    = (i + 1 == npts);
              pending_points.push_back(p);
            end
            frames_ok++;
          end
        end
      end
    endcase
  endtask

  task automatic check_point();
    point_t want;
    if (pending_points.size() == 0) begin
      miss_cnt++;
      if (miss_cnt <= REPORT_MAX)
        $display("unexpected point beat: angle %0d dist %0d conf %0d pt %0d frame %0d last %0d",
                 point_mon.angle_bin, point_mon.distance_mm, point_mon.confidence,
                 point_mon.point_number, point_mon.frame_number, point_mon.last_point);
    end else begin
      want = pending_points.pop_front();
      if (point_mon.angle_bin !== want.angle || point_mon.distance_mm !== want.dist_mm ||
          point_mon.confidence !== want.conf || point_mon.point_number !== want.pnum ||
          point_mon.frame_number !== want.fnum || point_mon.last_point !== want.last) begin
        miss_cnt++;
        if (miss_cnt <= REPORT_MAX) begin
          $display("point mismatch, expected: angle %0d dist %0d conf %0d pt %0d frame %0d last %0d",
                   want.angle, want.dist_mm, want.conf, want.pnum, want.fnum, want.last);
          $display("                 actual: angle %0d dist %0d conf %0d pt %0d frame %0d last %0d",
                   point_mon.angle_bin, point_mon.distance_mm, point_mon.confidence,
                   point_mon.point_number, point_mon.frame_number, point_mon.last_point);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase     = HUNT;
      pos       = 0;
      npts      = MAX_POINTS;
      crc_acc   = 8'h00;
      start_ang = 16'h0000;
      frames_ok = 16'h0000;
      hdr_val   = HEADER_RST;
      span_val  = SPAN_RST;
      miss_cnt  = 0;
      pending_points.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.addr)
          CFG_HEADER_IDX: hdr_val = cfg_mon.data[7:0];
          CFG_SPAN_IDX:   span_val = cfg_mon.data[SPAN_W-1:0];
          default: ;
        endcase
      end
      if (byte_mon.valid && byte_mon.ready) follow_byte(byte_mon.rx_byte);
      if (point_mon.valid && point_mon.ready) check_point();
    end
    pend_cnt_o = pending_points.size();
    fail_cnt_o = miss_cnt;
  end

endmodule

// ===== tb/sv/tb_lidar_frame_parser_crc8_unit.sv =====
// top of the lidar frame parser testbench: clock, reset, byte stimulus, config writes
// depends on lfpc_pkg, lfpc_if, lidar_frame_parser_crc8_unit and lfpc_point_checker
`timescale 1ns / 100ps

module tb_lidar_frame_parser_crc8_unit;
  import lfpc_pkg::*;

  localparam int          HOLD_CYCLES   = 400;   // long point-side stall under pressure
  localparam int unsigned WD_LIMIT      = 4000;  // cycles with no beat at all
  localparam int          SETTLE_CYCLES = 48;    // divider plus a full frame of points
  localparam int unsigned PHASE_BYTES   = 80;

  // how the point bytes of a frame get filled
  typedef enum logic [1:0] {FILL_RAND, FILL_ONES, FILL_ZERO, FILL_HDR} fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;

  lfpc_cfg_if  cfg_if ();
  lfpc_in_if   byte_if ();
  lfpc_out_if  point_if ();

  int unsigned fail_cnt;
  int unsigned pend_cnt;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  logic [7:0]  hdr_now;

  lidar_frame_parser_crc8_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (byte_if),
    .out_o  (point_if)
  );

  lfpc_point_checker point_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_mon    (cfg_if),
    .byte_mon   (byte_if),
    .point_mon  (point_if),
    .fail_cnt_o (fail_cnt),
    .pend_cnt_o (pend_cnt)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // point-side ready: random stalls, plus one long hold-off when asked
  initial begin : sink_ready
    bit held;
    held = 1'b0;
    point_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        point_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        held = 1'b1;
      end else begin
        point_if.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: any beat on any channel resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (point_if.valid && point_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WD_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // crc-8 for building frames, same polynomial as the link
  function automatic logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
    logic [7:0] x;
    int         k;
    x = c ^ b;
    for (k = 0; k < 8; k++) x = 8'(x << 1) ^ ({8{x[7]}} & CRC_POLY);
    return x;
  endfunction

  // one byte beat; entered and left just after a falling edge, valid left high
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid   = 1'b1;
    byte_if.rx_byte = b;
    do @(posedge clk_i); while (!byte_if.ready);
    @(negedge clk_i);
  endtask

  // header, write both registers back to back, valid stays high in between
  task automatic apply_config(input logic [7:0] hdr, input logic [15:0] span);
    cfg_if.valid = 1'b1;
    cfg_if.addr  = CFG_HEADER_IDX;
    cfg_if.data  = CFG_DATA_W'(hdr);
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.addr = CFG_SPAN_IDX;
    cfg_if.data = span;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    hdr_now      = hdr;
  endtask

  // stop sending, let every predicted point drain, then let the block go quiet
  task automatic settle();
    byte_if.valid = 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // full frame: header, len, speed, start angle, points, tail, crc
  task automatic send_frame(input logic [7:0] len_byte, input logic [15:0] start_ang,
                            input fill_e fill, input bit corrupt);
    logic [7:0]  frame_q [$];
    int unsigned npts;
    int unsigned i;
    logic [7:0]  crc;
    logic [7:0]  b;
    npts = len_byte & COUNT_MASK;
    if (npts == 0 || npts > MAX_POINTS) npts = MAX_POINTS;
    frame_q.push_back(hdr_now);
    frame_q.push_back(len_byte);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    frame_q.push_back(start_ang[7:0]);
    frame_q.push_back(start_ang[15:8]);
    for (i = 0; i < 3 * npts; i++) begin
      case (fill)
        FILL_ONES: b = 8'hFF;
        FILL_ZERO: b = 8'h00;
        FILL_HDR:  b = hdr_now;
        default:   b = 8'($urandom);
      endcase
      frame_q.push_back(b);
    end
    // end angle and timestamp, random, only covered by the crc
    repeat (4) frame_q.push_back(8'($urandom));
    crc = 8'h00;
    foreach (frame_q[k]) crc = crc8_next(crc, frame_q[k]);
    if (corrupt) crc ^= 8'(1 << $urandom_range(7));
    frame_q.push_back(crc);
    foreach (frame_q[k]) push_byte(frame_q[k]);
    bytes_sent += frame_q.size();
  endtask

  // line noise between frames, mostly avoiding the header value
  task automatic send_noise(input int unsigned len);
    logic [7:0] b;
    repeat (len) begin
      b = 8'($urandom);
      // a stray header now and then starts a bogus frame
      if (b == hdr_now && $urandom_range(9) != 0) b = ~b;
      push_byte(b);
    end
  endtask

  // mostly good frames with random content, some bad crc frames and noise
  task automatic random_traffic(input int tx_pct, input int rx_pct, input int unsigned nbytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned r;
    logic [4:0]  cnt;
    logic [15:0] ang;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick >= 88) begin
        send_noise($urandom_range(1, 8));
      end else begin
        // small frames most of the time, full and out-of-range counts now and then
        r = $urandom_range(99);
        if (r < 55)      cnt = 5'($urandom_range(1, 4));
        else if (r < 85) cnt = 5'($urandom_range(1, MAX_POINTS));
        else if (r < 92) cnt = 5'd0;
        else             cnt = 5'($urandom_range(MAX_POINTS + 1, 31));
        ang = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 35999)) : 16'($urandom);
        send_frame({3'($urandom), cnt}, ang, FILL_RAND, pick >= 76);
      end
    end
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.rx_byte = 8'h00;
    cfg_if.valid    = 1'b0;
    cfg_if.addr     = CFG_HEADER_IDX;
    cfg_if.data     = '0;
    hdr_now         = HEADER_RST;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed frames on reset register values
    // one point, all-ones payload, start angle past a full turn, high len bits set
    send_frame(8'hE1, 16'hFFFF, FILL_ONES, 1'b0);
    // all-zero payload at angle zero
    send_frame(8'h02, 16'h0000, FILL_ZERO, 1'b0);
    // bad crc: whole frame dropped, frame number stays
    send_frame(8'h02, 16'd9000, FILL_RAND, 1'b1);
    // bytes that are not the header are skipped in search
    push_byte(8'h00);
    push_byte(8'hFF);
    // count field zero means a full frame; header value inside the points is plain data
    send_frame(8'h20, 16'd18000, FILL_HDR, 1'b0);
    settle();

    // widest legal span, all-ones header
    apply_config(8'hFF, 16'd36000);
    send_frame(8'h0C, 16'd35999, FILL_RAND, 1'b0);
    // count above the maximum is clamped; len byte equals header here
    send_frame(8'hFF, 16'd35950, FILL_RAND, 1'b0);
    settle();

    // zero span, zero header
    apply_config(8'h00, 16'd0);
    send_frame(8'h03, 16'd12345, FILL_RAND, 1'b0);
    settle();

    // random traffic: slow-ish sender, very stalling receiver
    apply_config(8'($urandom), 16'($urandom_range(0, 36000)));
    random_traffic(22, 83, PHASE_BYTES);

    // random traffic: sparse sender, light stalls, span past one turn
    apply_config(8'($urandom), 16'hFFFF);
    random_traffic(83, 22, PHASE_BYTES);

    // back-to-back traffic; the receiver first holds off so the parser backs up
    apply_config(HEADER_RST, SPAN_RST);
    hold_req = 1'b1;
    random_traffic(0, 0, PHASE_BYTES);

    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
